[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/trd_pkg.sv]
`default_nettype none
package trd_pkg;

   localparam int DEF_FINGERS     = 5;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam int ID_W    = 3;
   localparam int COORD_W = 12;
   localparam int BYTE_W  = 8;
   localparam int CSR_A_W = 2;

   // input command codes (req_tuser)
   localparam logic [1:0] CMD_RECORD      = 2'd0;
   localparam logic [1:0] CMD_REPORT      = 2'd1;
   localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

   // record types, header bits 6:5
   localparam logic [1:0] REC_SCREEN = 2'd1;
   localparam logic [1:0] REC_KEY    = 2'd2;

   // configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_KEY0_X = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_KEY0_Y = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_KEY1_X = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_KEY1_Y = 2'd3;

   typedef enum logic [1:0] {
      KIND_TOUCH   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_SCREEN  = 2'd0,
      OP_KEY     = 2'd1,
      OP_REPORT  = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   // one classified transaction waiting for the back end
   typedef struct packed {
      op_type             op;
      logic [3:0]         id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [BYTE_W-1:0]  area;
      logic [BYTE_W-1:0]  pres;
   } entry_type;

endpackage
`default_nettype wire

[rtl/trd_front.sv]
`default_nettype none
module trd_front #(
   parameter int FINGERS = trd_pkg::DEF_FINGERS
) (
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [47:0]        req_tdata,
   input  wire logic [1:0]         req_tuser,
   input  wire logic               q_full,
   output logic                    push,
   output trd_pkg::entry_type      entry
);

   logic [7:0] hdr;
   logic [3:0] nib;
   logic [1:0] rec_type;
   logic       pressed;
   logic       keep;

   assign hdr      = req_tdata[7:0];
   assign nib      = hdr[3:0];
   assign rec_type = hdr[6:5];
   assign pressed  = hdr[7];

   always_comb begin
      keep       = 1'b0;
      entry.op   = trd_pkg::OP_SCREEN;
      entry.id   = nib - 4'd1;
      entry.x    = {req_tdata[11:8], req_tdata[23:16]};
      entry.y    = {req_tdata[15:12], req_tdata[31:24]};
      entry.area = req_tdata[39:32];
      entry.pres = pressed ? req_tdata[47:40] : 8'd0;
      case (req_tuser)
         trd_pkg::CMD_RECORD: begin
            if (rec_type == trd_pkg::REC_SCREEN) begin
               entry.op = trd_pkg::OP_SCREEN;
               keep     = (nib != 4'd0) && ({1'b0, nib} <= 5'(FINGERS));
            end else if (rec_type == trd_pkg::REC_KEY) begin
               entry.op = trd_pkg::OP_KEY;
               keep     = (nib == 4'd1) || (nib == 4'd2);
            end
         end
         trd_pkg::CMD_REPORT: begin
            entry.op = trd_pkg::OP_REPORT;
            keep     = 1'b1;
         end
         trd_pkg::CMD_RELEASE_ALL: begin
            entry.op = trd_pkg::OP_RELEASE;
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full && keep;

endmodule
`default_nettype wire

[rtl/trd_queue.sv]
`default_nettype none
module trd_queue #(
   parameter int DEPTH = trd_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire trd_pkg::entry_type entry_in,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output trd_pkg::entry_type      entry_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   trd_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign entry_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

[rtl/trd_back.sv]
`default_nettype none
module trd_back #(
   parameter int FINGERS = trd_pkg::DEF_FINGERS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_addr,
   input  wire logic [11:0]        csr_wdata,
   input  wire logic               q_empty,
   input  wire trd_pkg::entry_type q_entry,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [47:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int IDW = $clog2(FINGERS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDW-1:0] slot_ff, slot_in;
   logic           rel_ff, rel_in;
   logic           down_ff, down_in;

   logic [11:0] key0_x_ff, key0_y_ff, key1_x_ff, key1_y_ff;

   logic [FINGERS-1:0] active_ff, active_in;
   logic [11:0] fx_ff [FINGERS];
   logic [11:0] fx_in [FINGERS];
   logic [11:0] fy_ff [FINGERS];
   logic [11:0] fy_in [FINGERS];
   logic [7:0]  fa_ff [FINGERS];
   logic [7:0]  fa_in [FINGERS];
   logic [7:0]  fp_ff [FINGERS];
   logic [7:0]  fp_in [FINGERS];

   logic                 rv_ff, rv_in;
   trd_pkg::kind_type    rkind_ff, rkind_in;
   logic [2:0]           rid_ff, rid_in;
   logic [11:0]          rx_ff, rx_in;
   logic [11:0]          ry_ff, ry_in;
   logic [7:0]           ra_ff, ra_in;
   logic [7:0]           rp_ff, rp_in;
   logic                 rdown_ff, rdown_in;
   logic                 rlast_ff, rlast_in;

   logic           can_load;
   logic [IDW-1:0] wid;
   logic           last_slot;

   assign can_load  = !rv_ff || rsp_tready;
   assign wid       = q_entry.id[IDW-1:0];
   assign last_slot = (slot_ff == IDW'(FINGERS - 1));

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      rel_in    = rel_ff;
      down_in   = down_ff;
      active_in = active_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      fa_in     = fa_ff;
      fp_in     = fp_ff;
      pop       = 1'b0;
      rv_in     = rv_ff && !rsp_tready;
      rkind_in  = rkind_ff;
      rid_in    = rid_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      ra_in     = ra_ff;
      rp_in     = rp_ff;
      rdown_in  = rdown_ff;
      rlast_in  = rlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               case (q_entry.op)
                  trd_pkg::OP_SCREEN: begin
                     fx_in[wid]     = q_entry.x;
                     fy_in[wid]     = q_entry.y;
                     fa_in[wid]     = q_entry.area;
                     fp_in[wid]     = q_entry.pres;
                     active_in[wid] = 1'b1;
                  end
                  trd_pkg::OP_KEY: begin
                     // area of a key slot is left as it was
                     fx_in[wid]     = q_entry.id[0] ? key1_x_ff : key0_x_ff;
                     fy_in[wid]     = q_entry.id[0] ? key1_y_ff : key0_y_ff;
                     fp_in[wid]     = q_entry.pres;
                     active_in[wid] = 1'b1;
                  end
                  trd_pkg::OP_REPORT, trd_pkg::OP_RELEASE: begin
                     rel_in   = (q_entry.op == trd_pkg::OP_RELEASE);
                     slot_in  = '0;
                     down_in  = 1'b0;
                     state_in = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (!active_ff[slot_ff] || can_load) begin
               if (active_ff[slot_ff]) begin
                  rv_in    = 1'b1;
                  rid_in   = 3'(slot_ff);
                  rdown_in = 1'b0;
                  rlast_in = 1'b0;
                  if (fp_ff[slot_ff] == 8'd0) begin
                     rkind_in           = trd_pkg::KIND_RELEASE;
                     rx_in              = '0;
                     ry_in              = '0;
                     ra_in              = '0;
                     rp_in              = '0;
                     active_in[slot_ff] = 1'b0;
                  end else begin
                     rkind_in = trd_pkg::KIND_TOUCH;
                     rx_in    = fx_ff[slot_ff];
                     ry_in    = fy_ff[slot_ff];
                     ra_in    = rel_ff ? 8'd0 : fa_ff[slot_ff];
                     rp_in    = rel_ff ? 8'd0 : fp_ff[slot_ff];
                     if (rel_ff) begin
                        active_in[slot_ff] = 1'b0;
                     end else begin
                        down_in = 1'b1;
                     end
                  end
               end
               if (last_slot) begin
                  state_in = ST_SUM;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (can_load) begin
               rv_in    = 1'b1;
               rkind_in = trd_pkg::KIND_SUMMARY;
               rid_in   = '0;
               rx_in    = '0;
               ry_in    = '0;
               ra_in    = '0;
               rp_in    = '0;
               rdown_in = down_ff;
               rlast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         slot_ff   <= '0;
         rel_ff    <= 1'b0;
         down_ff   <= 1'b0;
         active_ff <= '0;
         rv_ff     <= 1'b0;
         for (int i = 0; i < FINGERS; i++) begin
            fa_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         rel_ff    <= rel_in;
         down_ff   <= down_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
         fa_ff     <= fa_in;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      fp_ff    <= fp_in;
      rkind_ff <= rkind_in;
      rid_ff   <= rid_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      ra_ff    <= ra_in;
      rp_ff    <= rp_in;
      rdown_ff <= rdown_in;
      rlast_ff <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_x_ff <= '0;
         key0_y_ff <= '0;
         key1_x_ff <= '0;
         key1_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            trd_pkg::CSR_KEY0_X: key0_x_ff <= csr_wdata;
            trd_pkg::CSR_KEY0_Y: key0_y_ff <= csr_wdata;
            trd_pkg::CSR_KEY1_X: key1_x_ff <= csr_wdata;
            trd_pkg::CSR_KEY1_Y: key1_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {4'd0, rdown_ff, rp_ff, ra_ff, ry_ff, rx_ff, rid_ff};

endmodule
`default_nettype wire

[rtl/touch_report_decoder_core.sv]
// Touch report decoder.
// req channel: one transaction per command. req_tuser = cmd (0 record,
// 1 report frame, 2 release all); req_tdata carries the six record bytes.
// rsp channel: finger reports, release markers and one frame summary per
// report or release-all; rsp_tuser = kind, rsp_tlast marks the summary.
// csr port: key0_x, key0_y, key1_x, key1_y at indexes 0..3, write only.
// A front stage classifies and drops invalid records, a queue of
// QUEUE_DEPTH entries decouples it from the back end, which owns the
// finger table and walks it one slot per cycle while no result waits
// on rsp_tready. A record passes through the queue before it reaches
// the table. The back end handles a report or release-all in steps
// (pop, table walk, summary) and pops no further command until the
// summary is loaded; a result waiting on rsp_tready stalls the walk.
// req_tready drops only while the queue is full, so rsp stalls back up
// through the queue. Reset clears the table's active flags and areas,
// the keys, the queue and output valid.
`default_nettype none
`include "assert_macros.svh"
module touch_report_decoder_core #(
   parameter int FINGERS     = trd_pkg::DEF_FINGERS,
   parameter int QUEUE_DEPTH = trd_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] record_header, [15:8] position_high, [23:16] x_low,
   // [31:24] y_low, [39:32] contact_area, [47:40] contact_pressure
   input  wire logic [47:0] req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] finger_id, [14:3] pos_x, [26:15] pos_y, [34:27] area_out,
   // [42:35] pressure_out, [43] touch_down, [47:44] zero
   output logic [47:0]      rsp_tdata,
   // [1:0] kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [11:0] csr_wdata
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   logic               rsp_is_sum;
   trd_pkg::entry_type f_entry;
   trd_pkg::entry_type q_entry;

   trd_front #(.FINGERS(FINGERS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .entry      (f_entry)
   );

   trd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (f_entry),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .entry_out (q_entry)
   );

   trd_back #(.FINGERS(FINGERS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_empty    (q_empty),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_is_sum = (rsp_tuser == trd_pkg::KIND_SUMMARY);

   `TRD_ASSERT_IMPL(a_no_overflow, clock, reset, push, !q_full)
   `TRD_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !q_empty)
   `TRD_ASSERT_IMPL(a_last_is_summary, clock, reset, rsp_tvalid, rsp_is_sum == rsp_tlast)
   `TRD_ASSERT_IMPL(a_down_only_summary, clock, reset, rsp_tvalid && !rsp_tlast, !rsp_tdata[43])

endmodule
`default_nettype wire
